// ===== sv/sscs_pkg.sv =====
// ============================================================================
// sscs_pkg
// Shared types and constants for the shaft synchronous clutch stepper:
// payload words, command codes, register indexes and register reset values.
// ============================================================================
package sscs_pkg;

    // command codes
    localparam logic [1:0] CMD_MOVE       = 2'd0;
    localparam logic [1:0] CMD_ENGAGE_FWD = 2'd1;
    localparam logic [1:0] CMD_ENGAGE_REV = 2'd2;
    localparam logic [1:0] CMD_DISENGAGE  = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_WINDOW   = 1'd1;

    // register reset values
    localparam logic [23:0] STEPS_PER_REV_RST = 24'd51200;
    localparam logic [15:0] LOCK_WINDOW_RST   = 16'd5120;

    // input word
    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] step_amount;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [8:0] shaft_movement;
        logic              locked;
        logic [23:0]       output_angle;
    } t_out_word;

endpackage

// ===== sv/sscs_core.sv =====
// ============================================================================
// sscs_core
// Clutch state and single-pass update: input angle wrap, lock test, fraction
// accumulation and whole-step emission. State advances on i_step.
// ============================================================================
module sscs_core
    import sscs_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int ANGLE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_word    i_word,
    input  logic [23:0] i_steps_per_rev,
    input  logic [15:0] i_lock_window,
    output t_out_word   o_word
);

    // accumulator and angle math widths
    localparam int SUM_W   = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int MOV_W   = SUM_W - FRAC_BITS;
    localparam int BASE_W  = (ANGLE_BITS > 24) ? ANGLE_BITS : 24;
    localparam int V_W     = ((BASE_W > SUM_W) ? BASE_W : SUM_W) + 2;
    localparam int D_W     = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
    localparam int FRAC_W  = FRAC_BITS + 1;

    // one conditional wrap into [0, steps_per_rev)
    function automatic logic [ANGLE_BITS-1:0] wrap_angle(
        input logic [ANGLE_BITS-1:0] angle,
        input logic signed [SUM_W-1:0] delta,
        input logic [23:0] spr
    );
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] s;
        v = $signed(V_W'(angle)) + V_W'(delta);
        s = $signed(V_W'(spr));
        if (v >= s) begin
            v = v - s;
        end else if (v < 0) begin
            v = v + s;
        end
        return v[ANGLE_BITS-1:0];
    endfunction

    // unwrapped distance below the lock window
    function automatic logic near_output(
        input logic [ANGLE_BITS-1:0] a,
        input logic [ANGLE_BITS-1:0] b,
        input logic [15:0] lw
    );
        logic signed [D_W-1:0] d;
        d = $signed(D_W'(a)) - $signed(D_W'(b));
        if (d < 0) begin
            d = -d;
        end
        return d < $signed(D_W'(lw));
    endfunction

    logic [ANGLE_BITS-1:0]   r_fwd_angle, n_fwd_angle;
    logic [ANGLE_BITS-1:0]   r_rev_angle, n_rev_angle;
    logic [ANGLE_BITS-1:0]   r_out_angle, n_out_angle;
    logic signed [FRAC_W-1:0] r_frac, n_frac;
    logic r_fwd_eng, n_fwd_eng;
    logic r_fwd_lock, n_fwd_lock;
    logic r_rev_eng, n_rev_eng;
    logic r_rev_lock, n_rev_lock;

    logic signed [SUM_W-1:0] amt_ext;
    logic signed [SUM_W-1:0] add;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    logic signed [MOV_W-1:0] quot;
    logic signed [SUM_W-1:0] delta_out;
    logic signed [SUM_W-1:0] rem;
    logic signed [31:0]      mov32;
    logic [31:0]             angle32;

    // next state for the item at hand
    always_comb begin
        n_fwd_angle = r_fwd_angle;
        n_rev_angle = r_rev_angle;
        n_out_angle = r_out_angle;
        n_frac      = r_frac;
        n_fwd_eng   = r_fwd_eng;
        n_fwd_lock  = r_fwd_lock;
        n_rev_eng   = r_rev_eng;
        n_rev_lock  = r_rev_lock;
        amt_ext     = SUM_W'(i_word.step_amount);
        add         = '0;
        sum         = '0;
        shifted     = '0;
        quot        = '0;
        delta_out   = '0;
        rem         = '0;
        case (i_word.command)
            CMD_MOVE: begin
                n_fwd_angle = wrap_angle(r_fwd_angle, amt_ext, i_steps_per_rev);
                n_rev_angle = wrap_angle(r_rev_angle, -amt_ext, i_steps_per_rev);
                // lock test uses new input angle and old output angle
                if (r_fwd_eng) begin
                    if (r_fwd_lock) begin
                        add = amt_ext;
                    end else if (near_output(n_fwd_angle, r_out_angle, i_lock_window)) begin
                        n_fwd_lock = 1'b1;
                    end
                end else if (r_rev_eng) begin
                    if (r_rev_lock) begin
                        add = -amt_ext;
                    end else if (near_output(n_rev_angle, r_out_angle, i_lock_window)) begin
                        n_rev_lock = 1'b1;
                    end
                end
                // whole steps, truncated toward zero
                sum     = SUM_W'(r_frac) + add;
                shifted = sum >>> FRAC_BITS;
                quot    = shifted[MOV_W-1:0];
                if (sum < 0 && sum[FRAC_BITS-1:0] != '0) begin
                    quot = quot + MOV_W'(1);
                end
                delta_out   = SUM_W'(quot) <<< FRAC_BITS;
                rem         = sum - delta_out;
                n_frac      = rem[FRAC_W-1:0];
                n_out_angle = wrap_angle(r_out_angle, delta_out, i_steps_per_rev);
            end
            CMD_ENGAGE_FWD: begin
                n_fwd_eng = 1'b1;
            end
            CMD_ENGAGE_REV: begin
                n_rev_eng = 1'b1;
            end
            CMD_DISENGAGE: begin
                n_fwd_eng  = 1'b0;
                n_fwd_lock = 1'b0;
                n_rev_eng  = 1'b0;
                n_rev_lock = 1'b0;
            end
            default: begin
                n_fwd_eng = r_fwd_eng;
            end
        endcase
    end

    // result word
    always_comb begin
        mov32                 = 32'(quot);
        angle32               = 32'(n_out_angle);
        o_word.shaft_movement = mov32[8:0];
        o_word.output_angle   = angle32[23:0];
        if (n_fwd_eng) begin
            o_word.locked = n_fwd_lock;
        end else if (n_rev_eng) begin
            o_word.locked = n_rev_lock;
        end else begin
            o_word.locked = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_angle <= '0;
            r_rev_angle <= '0;
            r_out_angle <= '0;
            r_frac      <= '0;
            r_fwd_eng   <= 1'b0;
            r_fwd_lock  <= 1'b0;
            r_rev_eng   <= 1'b0;
            r_rev_lock  <= 1'b0;
        end else if (i_step) begin
            r_fwd_angle <= n_fwd_angle;
            r_rev_angle <= n_rev_angle;
            r_out_angle <= n_out_angle;
            r_frac      <= n_frac;
            r_fwd_eng   <= n_fwd_eng;
            r_fwd_lock  <= n_fwd_lock;
            r_rev_eng   <= n_rev_eng;
            r_rev_lock  <= n_rev_lock;
        end
    end

    // disengage leaves every clutch flag clear
    a_disengage_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.command == CMD_DISENGAGE
        |=> !r_fwd_eng && !r_fwd_lock && !r_rev_eng && !r_rev_lock)
        else $error("clutch flags not cleared by disengage");

    // fraction remainder stays below one whole step
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_frac) < (SUM_W'(1) <<< FRAC_BITS))
        && (SUM_W'(r_frac) > -(SUM_W'(1) <<< FRAC_BITS)))
        else $error("step fraction out of range");

    // engage and disengage words move nothing
    a_cmd_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.command != CMD_MOVE |-> o_word.shaft_movement == '0)
        else $error("movement on a non-move command");

    // a clutch only locks on a move word
    a_lock_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_lock) || $rose(r_rev_lock)
        |-> $past(i_step && i_word.command == CMD_MOVE))
        else $error("lock set outside a move");

endmodule

// ===== sv/shaft_sync_clutch_stepper.sv =====
// ============================================================================
// shaft_sync_clutch_stepper
// Electronic synchronous clutch for a leadscrew: move words turn forward and
// reverse input angles, an engaged clutch locks near the output angle and then
// drives whole output steps from a Q.FRAC_BITS fraction accumulator.
// ============================================================================
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------
//  in       | input     | i_in_valid / o_in_ready      | i_in_word
//  out      | output    | o_out_valid / i_out_ready    | o_out_word
//  cfg      | input     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
//  one word per cycle while the output is not stalled; an accepted word passes
//  the input register, then the state update into the result buffer, before
//  its result is valid
//  the clutch state update is one pass of adds, wraps and one lock compare
//  synchronous active-low reset clears state, registers load reset values
//  a two-entry result buffer absorbs output stalls; o_in_ready comes from flops
//
module shaft_sync_clutch_stepper
    import sscs_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int ANGLE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [23:0] r_steps_per_rev;
    logic [15:0] r_lock_window;

    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_o_valid;
    t_out_word   r_o_word;
    logic        r_s_valid;
    t_out_word   r_s_word;

    logic        adv;
    logic        pop;
    t_out_word   core_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_rev <= STEPS_PER_REV_RST;
            r_lock_window   <= LOCK_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEPS_PER_REV: r_steps_per_rev <= i_cfg_data[23:0];
                REG_LOCK_WINDOW:   r_lock_window   <= i_cfg_data[15:0];
                default:           r_lock_window   <= r_lock_window;
            endcase
        end
    end

    // handshake control
    assign adv         = r_in_valid && !r_s_valid;
    assign pop         = r_o_valid && i_out_ready;
    assign o_in_ready  = !r_in_valid || !r_s_valid;
    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // clutch state and update
    sscs_core #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (adv),
        .i_word          (r_in_word),
        .i_steps_per_rev (r_steps_per_rev),
        .i_lock_window   (r_lock_window),
        .o_word          (core_word)
    );

    // result buffer valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (pop) begin
                r_s_valid <= 1'b0;
            end
        end else if (adv) begin
            if (!r_o_valid || pop) begin
                r_o_valid <= 1'b1;
            end else begin
                r_s_valid <= 1'b1;
            end
        end else if (pop) begin
            r_o_valid <= 1'b0;
        end
    end

    // result buffer words
    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (pop) begin
                r_o_word <= r_s_word;
            end
        end else if (adv) begin
            if (!r_o_valid || pop) begin
                r_o_word <= core_word;
            end else begin
                r_s_word <= core_word;
            end
        end
    end

    // skid entry only holds a word behind the head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("skid word without head word");

    // a word pushed into a full, stalled head lands in the skid
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_o_valid && !pop |=> r_s_valid)
        else $error("result word lost on stall");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_o_valid && !r_s_valid)
        else $error("pipeline not empty after reset");

endmodule

// ===== tb/shaft_sync_clutch_stepper_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shaft_sync_clutch_stepper_checker
// Watches the input, output and register ports of the clutch stepper. Keeps
// its own copy of the clutch state and register settings, predicts one
// result word per accepted input word, and compares each accepted result
// word field by field with the oldest prediction.
// ============================================================================
module shaft_sync_clutch_stepper_checker
    import sscs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending_cnt
);

    localparam int FRAC_BITS  = 8;
    localparam int STEP_SCALE = 1 << FRAC_BITS;

    // register copies
    logic [23:0] rev_steps;
    logic [15:0] lock_dist;

    // clutch state copy
    logic [23:0] fwd_angle;
    logic [23:0] rev_angle;
    logic [23:0] shaft_angle;
    int          step_frac;
    logic        fwd_engaged;
    logic        fwd_locked;
    logic        rev_engaged;
    logic        rev_locked;

    t_out_word   expected_motion[$];
    t_out_word   oldest_motion;
    int          fail_cnt = 0;

    // add a signed delta to an angle with a single wrap correction
    function automatic logic [23:0] turn_angle(logic [23:0] angle, longint delta);
        longint sum;
        longint span;
        sum  = angle;
        span = rev_steps;
        sum  = sum + delta;
        if (sum >= span)
            sum = sum - span;
        else if (sum < 0)
            sum = sum + span;
        return sum[23:0];
    endfunction

    // plain distance to the output angle, no wrap
    function automatic bit near_shaft(logic [23:0] angle);
        longint a;
        longint b;
        longint gap;
        longint win;
        a   = angle;
        b   = shaft_angle;
        win = lock_dist;
        gap = a - b;
        if (gap < 0)
            gap = -gap;
        return gap < win;
    endfunction

    // advance the clutch copy by one word and queue the result it yields
    task automatic predict_motion(input t_in_word w);
        int        amt;
        int        whole;
        t_out_word r;
        amt   = $signed(w.step_amount);
        whole = 0;
        case (w.command)
            CMD_MOVE: begin
                fwd_angle = turn_angle(fwd_angle, longint'(amt));
                rev_angle = turn_angle(rev_angle, -longint'(amt));
                // a clutch that locks on this word adds nothing yet
                if (fwd_engaged) begin
                    if (fwd_locked)
                        step_frac = step_frac + amt;
                    else if (near_shaft(fwd_angle))
                        fwd_locked = 1'b1;
                end else if (rev_engaged) begin
                    if (rev_locked)
                        step_frac = step_frac - amt;
                    else if (near_shaft(rev_angle))
                        rev_locked = 1'b1;
                end
                // whole steps truncate toward zero, remainder keeps the sign
                whole       = step_frac / STEP_SCALE;
                step_frac   = step_frac % STEP_SCALE;
                shaft_angle = turn_angle(shaft_angle, longint'(whole) * STEP_SCALE);
            end
            CMD_ENGAGE_FWD: fwd_engaged = 1'b1;
            CMD_ENGAGE_REV: rev_engaged = 1'b1;
            default: begin
                fwd_engaged = 1'b0;
                fwd_locked  = 1'b0;
                rev_engaged = 1'b0;
                rev_locked  = 1'b0;
            end
        endcase
        r.shaft_movement = whole[8:0];
        r.locked         = fwd_engaged ? fwd_locked : (rev_engaged ? rev_locked : 1'b0);
        r.output_angle   = shaft_angle;
        expected_motion.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, fname, want, got);
            fail_cnt++;
        end
    endtask

    // sample all ports on the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rev_steps   = STEPS_PER_REV_RST;
            lock_dist   = LOCK_WINDOW_RST;
            fwd_angle   = '0;
            rev_angle   = '0;
            shaft_angle = '0;
            step_frac   = 0;
            fwd_engaged = 1'b0;
            fwd_locked  = 1'b0;
            rev_engaged = 1'b0;
            rev_locked  = 1'b0;
            fail_cnt    = 0;
            expected_motion.delete();
        end else begin
            // outgoing word is checked before this edge's input is predicted
            if (i_out_valid && i_out_ready) begin
                if (expected_motion.size() == 0) begin
                    $display("%0t ns: result word mismatch, expected none, got %h",
                             $time, i_out_word);
                    fail_cnt++;
                end else begin
                    oldest_motion = expected_motion.pop_front();
                    check_field("shaft_movement", 24'(oldest_motion.shaft_movement),
                                24'(i_out_word.shaft_movement));
                    check_field("locked", 24'(oldest_motion.locked),
                                24'(i_out_word.locked));
                    check_field("output_angle", oldest_motion.output_angle,
                                i_out_word.output_angle);
                end
            end
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == REG_STEPS_PER_REV)
                    rev_steps = i_cfg_data[23:0];
                else if (i_cfg_index == REG_LOCK_WINDOW)
                    lock_dist = i_cfg_data[15:0];
            end
            if (i_in_valid && i_in_ready)
                predict_motion(i_in_word);
        end
        o_fail_cnt    <= fail_cnt;
        o_pending_cnt <= expected_motion.size();
    end

endmodule

// ===== tb/shaft_sync_clutch_stepper_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// shaft_sync_clutch_stepper_tb
// Drives the clutch stepper with a short directed run of lock, wrap and
// fraction cases, then with random engage, move and release sequences under
// several register settings, with bursty input and a stalling receiver. The
// checker predicts and compares every result word.
// ============================================================================
module shaft_sync_clutch_stepper_tb;
    import sscs_pkg::*;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_WORDS  = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_PULSE} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int       fail_cnt;
    int       pending_cnt;
    int       cycle_cnt = 0;
    int       words_sent = 0;
    int       burst_left = 0;
    int       stall_left = 0;
    t_rx_mode stall_mode = RX_OPEN;

    shaft_sync_clutch_stepper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    shaft_sync_clutch_stepper_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_word    (o_out_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls, with a new random pattern whenever the current one runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(3));
            stall_left = $urandom_range(300, 20);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_OPEN:  i_out_ready <= 1'b1;
            RX_COIN:  i_out_ready <= ($urandom_range(1) == 0);
            RX_SLOW:  i_out_ready <= ($urandom_range(7) == 0);
            default:  i_out_ready <= stall_left[2];
        endcase
    end

    // step amount mix: corners, small, medium and full range
    function automatic logic [15:0] rand_amount();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(6))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'hffff;
                3: return 16'h0000;
                4: return 16'h0001;
                5: return 16'h0100;
                default: return 16'hff00;
            endcase
        end
        if (pick < 40)
            return 16'($urandom_range(1024) - 512);
        if (pick < 60)
            return 16'($urandom_range(8192) - 4096);
        return 16'($urandom);
    endfunction

    // send one word, then maybe end the burst with a gap
    task automatic push_word(input logic [1:0] cmd, input logic [15:0] amt);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= '{command: cmd, step_amount: amt};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(60, 1);
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // wait until every predicted word has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers, back to back
    task automatic write_settings(input logic [23:0] spr, input logic [15:0] win);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_STEPS_PER_REV;
        i_cfg_data  <= spr;
        @(posedge i_clk);
        i_cfg_index <= REG_LOCK_WINDOW;
        i_cfg_data  <= CFG_DATA_W'(win);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly engage, run moves, release; sometimes random noise
    task automatic run_sequence();
        int         n;
        logic [1:0] cmd;
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(3))
                0: push_word(CMD_ENGAGE_FWD, 16'($urandom));
                1: push_word(CMD_ENGAGE_REV, 16'($urandom));
                2: begin
                    push_word(CMD_ENGAGE_FWD, 16'($urandom));
                    push_word(CMD_ENGAGE_REV, 16'($urandom));
                end
                default: begin
                    push_word(CMD_ENGAGE_REV, 16'($urandom));
                    push_word(CMD_ENGAGE_FWD, 16'($urandom));
                end
            endcase
            n = $urandom_range(40, 4);
            repeat (n) push_word(CMD_MOVE, rand_amount());
            if ($urandom_range(3) != 0)
                push_word(CMD_DISENGAGE, 16'($urandom));
        end else begin
            n = $urandom_range(8, 1);
            repeat (n) begin
                cmd = 2'($urandom_range(3));
                push_word(cmd, rand_amount());
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [23:0] spr;
        logic [15:0] win;
        int          phase_end;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: angle wraps both ways, extreme amounts, lock, fractions
        push_word(CMD_MOVE, 16'h0000);
        push_word(CMD_MOVE, 16'h7fff);
        push_word(CMD_MOVE, 16'h7fff);
        push_word(CMD_MOVE, 16'h8000);
        push_word(CMD_ENGAGE_FWD, 16'h1234);
        // brings forward angle onto the output angle exactly, locks without adding
        push_word(CMD_MOVE, 16'h4802);
        push_word(CMD_MOVE, 16'h7fff);
        push_word(CMD_MOVE, 16'h8000);
        // negative fractions truncate toward zero
        push_word(CMD_MOVE, 16'hff80);
        push_word(CMD_MOVE, 16'hff00);
        // engage again keeps lock, both engaged gives forward priority
        push_word(CMD_ENGAGE_FWD, 16'hffff);
        push_word(CMD_ENGAGE_REV, 16'h0000);
        push_word(CMD_MOVE, 16'h0100);
        push_word(CMD_DISENGAGE, 16'h5a5a);
        push_word(CMD_MOVE, 16'h0300);
        push_word(CMD_ENGAGE_REV, 16'ha5a5);
        push_word(CMD_MOVE, 16'h0000);
        push_word(CMD_MOVE, 16'hec78);
        push_word(CMD_MOVE, 16'h1388);
        push_word(CMD_MOVE, 16'h8000);
        push_word(CMD_MOVE, 16'h7fff);
        push_word(CMD_MOVE, 16'hffff);
        push_word(CMD_DISENGAGE, 16'h0000);
        drain_results();

        // random phases, register extremes first
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    spr = 24'd32768;
                    win = 16'd0;
                end
                1: begin
                    spr = 24'd16777215;
                    win = 16'd65535;
                end
                2: begin
                    spr = 24'd32768;
                    win = 16'd65535;
                end
                3: begin
                    spr = 24'd51200;
                    win = 16'd5120;
                end
                4: begin
                    spr = 24'd16777215;
                    win = 16'($urandom_range(2000));
                end
                default: begin
                    spr = 24'($urandom_range(16777215, 32768));
                    win = 16'($urandom_range(65535));
                end
            endcase
            write_settings(spr, win);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
                run_sequence();
            drain_results();
        end

        @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
